>>> rtl/stable_insertion_sorter_assert.svh
// ----------------------------------------------------------------------------
// stable insertion sorter assertion macros
// concurrent checks, compiled away for synthesis
// ----------------------------------------------------------------------------
`ifndef STABLE_INSERTION_SORTER_ASSERT_SVH
`define STABLE_INSERTION_SORTER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define SIS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sis assertion failed");

// next-cycle implication, disabled during reset
`define SIS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sis assertion failed");

`else

`define SIS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SIS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg
// types shared by the stable insertion sorter modules
// ----------------------------------------------------------------------------
package sis_pkg;

	localparam int KEY_W = 16;
	localparam int TAG_W = 8;

	// input record
	typedef struct packed {
		logic [KEY_W-1:0] cost_key;
		logic [TAG_W-1:0] record_tag;
		logic             end_of_run;
	} rec_t;

	// sorted result
	typedef struct packed {
		logic [KEY_W-1:0] sorted_key;
		logic [TAG_W-1:0] sorted_tag;
		logic             last_result;
		logic             overflow_seen;
	} res_t;

	// one stored record
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	// what a cell hands to its right neighbor
	typedef struct packed {
		entry_t entry;
		logic   occ;
		logic   gt;
	} link_t;

	// broadcast command to every cell
	typedef struct packed {
		logic   insert;
		logic   pop;
		entry_t entry;
	} cell_cmd_t;

endpackage

>>> rtl/sis_cell.sv
// ----------------------------------------------------------------------------
// sis_cell
// one slot of the sorted chain: compare, shift right on insert, left on pop
// ----------------------------------------------------------------------------
module sis_cell (
	input  logic               clk,
	input  sis_pkg::cell_cmd_t cmd,
	input  logic               occ,
	input  sis_pkg::link_t     left,
	input  sis_pkg::entry_t    right,
	output sis_pkg::link_t     self
);

	sis_pkg::entry_t data_q;
	logic            gt;
	logic            load;

	// strict compare keeps equal keys in arrival order
	assign gt   = occ && (data_q.key > cmd.entry.key);
	assign load = cmd.insert && (!occ || gt) && (left.gt || left.occ);

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			data_q <= right;
		end else if (load) begin
			data_q <= left.gt ? left.entry : cmd.entry;
		end
	end

	assign self = '{entry: data_q, occ: occ, gt: gt};

endmodule

>>> rtl/sis_chain.sv
// ----------------------------------------------------------------------------
// sis_chain
// row of sorting cells, slot 0 holds the smallest key
// ----------------------------------------------------------------------------
module sis_chain #(
	parameter int MAX_RECORDS = 16,
	localparam int FILL_W = $clog2(MAX_RECORDS + 1)
) (
	input  logic               clk,
	input  sis_pkg::cell_cmd_t cmd,
	input  logic [FILL_W-1:0]  fill,
	output sis_pkg::entry_t    head
);

	sis_pkg::link_t  links [MAX_RECORDS];
	sis_pkg::link_t  lefts [MAX_RECORDS];
	sis_pkg::entry_t rights [MAX_RECORDS];

	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		if (i == 0) begin : g_first
			// virtual occupied neighbor that is never greater
			assign lefts[i] = '{entry: cmd.entry, occ: 1'b1, gt: 1'b0};
		end else begin : g_mid
			assign lefts[i] = links[i-1];
		end

		if (i == MAX_RECORDS - 1) begin : g_last
			assign rights[i] = cmd.entry;
		end else begin : g_inner
			assign rights[i] = links[i+1].entry;
		end

		sis_cell u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.occ   (fill > FILL_W'(i)),
			.left  (lefts[i]),
			.right (rights[i]),
			.self  (links[i])
		);
	end

	assign head = links[0].entry;

endmodule

>>> rtl/stable_insertion_sorter.sv
// ----------------------------------------------------------------------------
// stable_insertion_sorter
// run-based stable insertion sorter built on a chain of compare/shift cells
// ----------------------------------------------------------------------------
// channel | direction | payload       | handshake
// rec     | in        | sis_pkg::rec_t | rec_valid / rec_ready
// res     | out       | sis_pkg::res_t | res_valid / res_ready
//
// every record of a run inserts in parallel: all cells compare against the
// broadcast key at once and the larger ones shift one slot right
// the record marked end_of_run starts a drain of one result per cycle out of
// slot 0 while the result register is free; rec_ready is low while
// draining
// arst_n clears the fill count, drop flag, drain state and result valid;
// the cell contents need no reset
// a stalled result register holds the drain; inserts do not depend on res
// ----------------------------------------------------------------------------
`include "stable_insertion_sorter_assert.svh"

module stable_insertion_sorter #(
	parameter int MAX_RECORDS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rec_valid,
	output logic          rec_ready,
	input  sis_pkg::rec_t rec,
	output logic          res_valid,
	input  logic          res_ready,
	output sis_pkg::res_t res
);

	localparam int FILL_W = $clog2(MAX_RECORDS + 1);

	logic [FILL_W-1:0]  fill_q;
	logic               dropped_q;
	logic               draining_q;
	logic               res_valid_q;
	sis_pkg::res_t      res_q;
	sis_pkg::cell_cmd_t cmd;
	sis_pkg::entry_t    head;
	logic               rec_xfer;
	logic               full;
	logic               pop;
	logic               last_pop;

	// input side: take records whenever no drain is running
	assign rec_ready = !draining_q;
	assign rec_xfer  = rec_valid && rec_ready;
	assign full      = (fill_q == FILL_W'(MAX_RECORDS));

	// output side: move the head into the result register when it is free
	assign pop      = draining_q && (!res_valid_q || res_ready);
	assign last_pop = pop && (fill_q == FILL_W'(1));

	// one command drives every cell: insert and pop never overlap
	assign cmd = '{
		insert: rec_xfer && !full,
		pop:    pop,
		entry:  '{key: rec.cost_key, tag: rec.record_tag}
	};

	sis_chain #(
		.MAX_RECORDS (MAX_RECORDS)
	) u_chain (
		.clk  (clk),
		.cmd  (cmd),
		.fill (fill_q),
		.head (head)
	);

	// run control: fill count, drop flag, drain phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			dropped_q  <= 1'b0;
			draining_q <= 1'b0;
		end else begin
			if (rec_xfer) begin
				if (full) begin
					// record beyond capacity is dropped, flag rides on the run
					dropped_q <= 1'b1;
				end else begin
					fill_q <= fill_q + FILL_W'(1);
				end
				if (rec.end_of_run) begin
					draining_q <= 1'b1;
				end
			end else if (pop) begin
				fill_q <= fill_q - FILL_W'(1);
				if (last_pop) begin
					// run finished, list empty for the next one
					draining_q <= 1'b0;
					dropped_q  <= 1'b0;
				end
			end
		end
	end

	// result register decouples the drain from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= '{
				sorted_key:    head.key,
				sorted_tag:    head.tag,
				last_result:   (fill_q == FILL_W'(1)),
				overflow_seen: dropped_q
			};
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// fill count stays within the chain
	`SIS_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FILL_W'(MAX_RECORDS))

	// a drain always has something left to pop
	`SIS_ASSERT_IMP(a_drain_nonempty, clk, arst_n, draining_q, fill_q != '0)

	// popping the final record closes the run and clears its drop flag
	`SIS_ASSERT_NXT(a_run_close, clk, arst_n, last_pop,
		!draining_q && fill_q == '0 && !dropped_q && res_valid && res.last_result)

	// an accepted record with room left grows the list by one
	`SIS_ASSERT_NXT(a_insert_grow, clk, arst_n, rec_xfer && !full,
		fill_q == $past(fill_q) + FILL_W'(1))

endmodule
